// ===== rtl/strict_utf8_validator_defines.svh =====
// Assertion macros used by the checker file of the UTF-8 validator.
`ifndef STRICT_UTF8_VALIDATOR_DEFINES_SVH
`define STRICT_UTF8_VALIDATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SUV_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("suv check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SUV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("suv check failed");

`endif

// ===== rtl/suv_pkg.sv =====
// Types and constants of the strict UTF-8 validator.
package suv_pkg;

  // Byte classes
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] LEAD2_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MIN = 8'hE0;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MIN = 8'hF0;
  localparam logic [7:0] LEAD4_MAX = 8'hF4;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG  = 8'h80;
  localparam logic [7:0] NUL_BYTE  = 8'h00;

  // Code point limits
  localparam int unsigned CP_W = 21;
  localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_MIN  = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_MAX  = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_TWO   = 21'h000080;
  localparam logic [CP_W-1:0] MIN_THREE = 21'h000800;
  localparam logic [CP_W-1:0] MIN_FOUR  = 21'h010000;

  // Sequence length classes
  localparam logic [1:0] LEN_NONE  = 2'd0;
  localparam logic [1:0] LEN_TWO   = 2'd1;
  localparam logic [1:0] LEN_THREE = 2'd2;
  localparam logic [1:0] LEN_FOUR  = 2'd3;

  // Continuation bytes still expected
  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_ONE   = 2'd1;
  localparam logic [1:0] PEND_TWO   = 2'd2;
  localparam logic [1:0] PEND_THREE = 2'd3;

  localparam int unsigned OUT_TDATA_W = 8;

  typedef struct packed {
    logic            err;
    logic [1:0]      len_class;
    logic [1:0]      pending;
    logic [CP_W-1:0] acc;
  } suv_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_text;
  } suv_item_t;

  typedef struct packed {
    logic error_seen;
    logic text_valid;
    logic text_done;
  } suv_result_t;

endpackage

// ===== rtl/suv_step.sv =====
// Per-byte decode: next validator state and result for one item.
module suv_step
  import suv_pkg::*;
(
  input  suv_item_t   item,
  input  suv_state_t  st,
  output suv_state_t  st_nxt,
  output suv_result_t res
);

  logic [CP_W-1:0] cp_shift;
  logic [CP_W-1:0] cp_min;
  logic            cp_bad;
  logic            is_cont;
  logic            text_ok;
  suv_state_t      nx;

  // Shift in six payload bits of a continuation byte
  assign cp_shift = {st.acc[CP_W-7:0], item.data_byte[5:0]};
  assign is_cont  = (item.data_byte & CONT_MASK) == CONT_TAG;

  // Overlong minimum for the sequence length
  always_comb begin
    unique case (st.len_class)
      LEN_TWO:   cp_min = MIN_TWO;
      LEN_THREE: cp_min = MIN_THREE;
      default:   cp_min = MIN_FOUR;
    endcase
  end

  assign cp_bad = (cp_shift < cp_min) || (cp_shift > CP_MAX) ||
                  ((cp_shift >= SURR_MIN) && (cp_shift <= SURR_MAX));

  // Byte consumption
  always_comb begin
    nx = st;
    if (item.byte_present && !st.err) begin
      if (st.pending == PEND_NONE) begin
        priority if (item.data_byte == NUL_BYTE) begin
          nx.err = 1'b1;
        end else if (item.data_byte <= ASCII_MAX) begin
          nx.pending = PEND_NONE;
        end else if (item.data_byte >= LEAD2_MIN && item.data_byte <= LEAD2_MAX) begin
          nx.pending   = PEND_ONE;
          nx.acc       = {{(CP_W-5){1'b0}}, item.data_byte[4:0]};
          nx.len_class = LEN_TWO;
        end else if (item.data_byte >= LEAD3_MIN && item.data_byte <= LEAD3_MAX) begin
          nx.pending   = PEND_TWO;
          nx.acc       = {{(CP_W-4){1'b0}}, item.data_byte[3:0]};
          nx.len_class = LEN_THREE;
        end else if (item.data_byte >= LEAD4_MIN && item.data_byte <= LEAD4_MAX) begin
          nx.pending   = PEND_THREE;
          nx.acc       = {{(CP_W-3){1'b0}}, item.data_byte[2:0]};
          nx.len_class = LEN_FOUR;
        end else begin
          nx.err = 1'b1;
        end
      end else begin
        if (!is_cont) begin
          nx.err = 1'b1;
        end else begin
          nx.acc     = cp_shift;
          nx.pending = st.pending - 2'd1;
          // Last continuation: range, overlong and surrogate checks
          if (st.pending == PEND_ONE) begin
            if (cp_bad) begin
              nx.err = 1'b1;
            end
            nx.acc       = '0;
            nx.len_class = LEN_NONE;
          end
        end
      end
      // An error drops any partial sequence
      if (nx.err) begin
        nx.pending   = PEND_NONE;
        nx.acc       = '0;
        nx.len_class = LEN_NONE;
      end
    end
  end

  // Verdict on end of text, which also clears the state
  assign text_ok = !nx.err && (nx.pending == PEND_NONE);

  always_comb begin
    if (item.end_of_text) begin
      res.error_seen = !text_ok;
      res.text_valid = text_ok;
      res.text_done  = 1'b1;
      st_nxt         = '0;
    end else begin
      res.error_seen = nx.err;
      res.text_valid = 1'b0;
      res.text_done  = 1'b0;
      st_nxt         = nx;
    end
  end

endmodule

// ===== rtl/strict_utf8_validator.sv =====
// Top level of the strict UTF-8 validator: input register, decode, result register.
// Checks a byte stream for strict UTF-8 (no NUL, no overlong forms, no surrogates,
// nothing above 10FFFF), one byte per transfer on the in_ side; every input transfer
// gives exactly one result transfer on the out_ side. in_tlast closes a text and its
// result carries the verdict with out_tlast high; in_tuser low with in_tlast high closes
// a text without adding a byte. Throughput is one byte per clock while out_tready is
// high, set by the single decode step between the input register and the result
// register, which also carries the sequence state from one byte to the next. Each item
// passes the input register and then the result register before out_tvalid rises; a
// stalled result keeps the next item in the input register and drops in_tready. No
// configuration; reset clears the text state.
module strict_utf8_validator
  import suv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] data_byte
  input  logic                   in_tuser,   // [0] byte_present
  input  logic                   in_tlast,   // end_of_text
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] error_seen, [1] text_valid, [7:2] zero
  output logic                   out_tlast   // text_done
);

  logic        s1_valid_r, s1_valid_nxt;
  suv_item_t   s1_item_r;
  logic        out_valid_r, out_valid_nxt;
  suv_result_t out_res_r;
  suv_state_t  state_r, state_nxt;
  suv_result_t step_res;
  logic        advance;
  logic        in_xfer;

  // Input stage moves on when the result register is free or being drained
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;

  suv_step u_step (
    .item   (s1_item_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (step_res)
  );

  assign s1_valid_nxt  = in_xfer || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  // Control and text state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= '{data_byte: in_tdata, byte_present: in_tuser, end_of_text: in_tlast};
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-2){1'b0}}, out_res_r.text_valid, out_res_r.error_seen};
  assign out_tlast  = out_res_r.text_done;

endmodule

// ===== rtl/suv_chk.sv =====
// Port-level checker for the strict UTF-8 validator, bound to the top level.
`include "strict_utf8_validator_defines.svh"

module suv_chk
  import suv_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  logic [OUT_TDATA_W:0] out_word;

  // Whole result word, tlast on top
  assign out_word = {out_tlast, out_tdata};

  // A stalled result holds
  `SUV_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_word))

  // Verdict and error flag disagree on the closing result
  `SUV_ASSERT_IMPLY(a_verdict, out_tvalid && out_tlast, out_tdata[1] != out_tdata[0])

  // Mid-text results never claim a valid text
  `SUV_ASSERT_IMPLY(a_mid_text, out_tvalid && !out_tlast, !out_tdata[1])

  // Padding bits stay zero
  `SUV_ASSERT_IMPLY(a_pad_zero, out_tvalid, out_tdata[OUT_TDATA_W-1:2] == '0)

endmodule

bind strict_utf8_validator suv_chk u_suv_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== tb/strict_utf8_validator_tb.sv =====
// Self-checking testbench for the strict UTF-8 validator: directed and random texts, verdict tracking.
module strict_utf8_validator_tb;
  import suv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TOTAL_ITEMS    = 1750;
  localparam int unsigned CALM_FROM      = 1450;  // no idling past this many items
  localparam int unsigned STALL_LIMIT    = 1000;  // cycles without any transfer
  localparam int unsigned DRAIN_CYCLES   = 20;

  // Tracks the text state and keeps the verdicts still owed by the block
  class utf8_verdict_tracker;
    logic [1:0]      pend;
    logic [CP_W-1:0] acc;
    logic [1:0]      len;
    logic            err;
    suv_result_t     expected_verdicts[$];
    int unsigned     failures;

    function new();
      clear_text();
      failures = 0;
    endfunction

    function void clear_text();
      pend = PEND_NONE;
      acc  = '0;
      len  = LEN_NONE;
      err  = 1'b0;
    endfunction

    // One byte of the text through the decoder
    function void take_byte(logic [7:0] b);
      logic [CP_W-1:0] floor_cp;
      if (err) return;
      if (pend == PEND_NONE) begin
        if (b == NUL_BYTE) begin
          err = 1'b1;
        end else if (b <= ASCII_MAX) begin
          // single-byte code point, nothing kept
        end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
          pend = PEND_ONE;
          acc  = CP_W'(b[4:0]);
          len  = LEN_TWO;
        end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
          pend = PEND_TWO;
          acc  = CP_W'(b[3:0]);
          len  = LEN_THREE;
        end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
          pend = PEND_THREE;
          acc  = CP_W'(b[2:0]);
          len  = LEN_FOUR;
        end else begin
          err = 1'b1;
        end
      end else if ((b & CONT_MASK) != CONT_TAG) begin
        err = 1'b1;
      end else begin
        acc  = {acc[CP_W-7:0], b[5:0]};
        pend = pend - 2'd1;
        if (pend == PEND_NONE) begin
          case (len)
            LEN_TWO:   floor_cp = MIN_TWO;
            LEN_THREE: floor_cp = MIN_THREE;
            default:   floor_cp = MIN_FOUR;
          endcase
          // overlong, out of range or surrogate
          if (acc < floor_cp || acc > CP_MAX || (acc >= SURR_MIN && acc <= SURR_MAX))
            err = 1'b1;
          acc = '0;
          len = LEN_NONE;
        end
      end
      if (err) begin
        pend = PEND_NONE;
        acc  = '0;
        len  = LEN_NONE;
      end
    endfunction

    // Called for every accepted input transfer
    function void note_item(suv_item_t it);
      suv_result_t r;
      logic ok;
      if (it.byte_present) take_byte(it.data_byte);
      if (it.end_of_text) begin
        ok = !err && (pend == PEND_NONE);
        r.error_seen = !ok;
        r.text_valid = ok;
        r.text_done  = 1'b1;
        clear_text();
      end else begin
        r.error_seen = err;
        r.text_valid = 1'b0;
        r.text_done  = 1'b0;
      end
      expected_verdicts = {expected_verdicts, r};
    endfunction

    // Called for every accepted result transfer
    function void check_verdict(suv_result_t got);
      suv_result_t want;
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result: error_seen %0b text_valid %0b text_done %0b",
               got.error_seen, got.text_valid, got.text_done);
        failures++;
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.error_seen !== want.error_seen) begin
        $error("error_seen: expected %0b, actual %0b", want.error_seen, got.error_seen);
        failures++;
      end
      if (got.text_valid !== want.text_valid) begin
        $error("text_valid: expected %0b, actual %0b", want.text_valid, got.text_valid);
        failures++;
      end
      if (got.text_done !== want.text_done) begin
        $error("text_done: expected %0b, actual %0b", want.text_done, got.text_done);
        failures++;
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;
  logic                   in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  logic                   idle_on;
  int unsigned            items_sent;
  int unsigned            quiet_cycles;
  logic [7:0]             text_bytes[$];
  utf8_verdict_tracker    board = new();

  strict_utf8_validator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Reset, released at a falling edge
  initial begin
    rst_n = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
  end

  // Result side: random stall bursts while idling is on
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Result check
  always @(posedge clk) begin
    suv_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.error_seen = out_tdata[0];
      got.text_valid = out_tdata[1];
      got.text_done  = out_tlast;
      board.check_verdict(got);
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic suv_item_t mk_item(logic [7:0] b, logic present, logic last);
    suv_item_t it;
    it.data_byte    = b;
    it.byte_present = present;
    it.end_of_text  = last;
    return it;
  endfunction

  // Appends one byte to the text being built
  function automatic void add_byte(logic [7:0] b);
    text_bytes = {text_bytes, b};
  endfunction

  // One input transfer; entered and left at a falling edge
  task automatic send_item(suv_item_t it);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it.data_byte;
    in_tuser  <= it.byte_present;
    in_tlast  <= it.end_of_text;
    do @(posedge clk); while (!in_tready);
    board.note_item(it);
    if (it.byte_present || it.end_of_text) items_sent++;
    @(negedge clk);
  endtask

  // Sends text_bytes as one text, closed on the last byte or by an end-only item
  task automatic send_text(bit end_separate);
    int unsigned n;
    n = text_bytes.size();
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
      send_item(mk_item(text_bytes[i], 1'b1, !end_separate && i == n - 1));
    end
    if (end_separate || n == 0)
      send_item(mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
  endtask

  // Encodes a code point in the given byte count, overlong or out of range if asked
  task automatic add_code(logic [20:0] cp, int unsigned n);
    case (n)
      1: add_byte({1'b0, cp[6:0]});
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Mostly legal code points, some near the limits, a few arbitrary
  task automatic pick_code(output logic [20:0] cp, output int unsigned n);
    logic [20:0] limit_cps[16];
    int unsigned sel;
    limit_cps = '{21'h0, 21'h1, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD7FF, 21'hD800,
                  21'hDFFF, 21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF, 21'h110000,
                  21'h1FFFFF, 21'hC1};
    sel = $urandom_range(0, 99);
    if (sel < 80) begin
      n = $urandom_range(1, 4);
      case (n)
        1: cp = 21'($urandom_range(1, 'h7F));
        2: cp = 21'($urandom_range('h80, 'h7FF));
        3: begin
          cp = 21'($urandom_range('h800, 'hFFFF));
          if (cp >= SURR_MIN && cp <= SURR_MAX) cp = cp - 21'h800;
        end
        default: cp = 21'($urandom_range('h10000, 'h10FFFF));
      endcase
    end else if (sel < 92) begin
      cp = limit_cps[$urandom_range(0, 15)];
      n = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
      // sometimes one byte too many: an overlong form
      if (n < 4 && $urandom_range(0, 2) == 0) n++;
    end else begin
      cp = 21'($urandom());
      n = $urandom_range(1, 4);
    end
  endtask

  // Stimulus
  initial begin
    logic [20:0] cp;
    int unsigned n;
    int unsigned ncp;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    in_tlast   = 1'b0;
    idle_on    = 1'b1;
    items_sent = 0;
    @(posedge rst_n);
    @(negedge clk);

    // Directed: empty text, NUL, range limits, overlong, surrogate, bad leads, cut-off
    send_item(mk_item(8'hA5, 1'b0, 1'b1));
    text_bytes = '{8'h00};                      send_text(1'b0);
    text_bytes = '{8'hC2, 8'h80};               send_text(1'b0);
    text_bytes = '{8'hE0, 8'h9F, 8'hBF};        send_text(1'b0);
    text_bytes = '{8'hED, 8'hA0, 8'h80};        send_text(1'b1);
    text_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_text(1'b0);
    text_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_text(1'b0);
    send_item(mk_item(8'hFF, 1'b1, 1'b0));
    send_item(mk_item(8'h5A, 1'b0, 1'b0));
    send_item(mk_item(8'h7F, 1'b1, 1'b1));
    text_bytes = '{8'hE2, 8'h82};               send_text(1'b0);
    text_bytes = '{8'hC1};                      send_text(1'b1);

    // Random texts
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= CALM_FROM) idle_on = 1'b0;
      text_bytes.delete();
      ncp = $urandom_range(0, 6);
      repeat (ncp) begin
        if ($urandom_range(0, 15) == 0) begin
          add_byte(8'($urandom_range(0, 255)));
        end else begin
          pick_code(cp, n);
          add_code(cp, n);
        end
      end
      // occasionally cut the text short
      if (text_bytes.size() > 0 && $urandom_range(0, 9) == 0) void'(text_bytes.pop_back());
      send_text(1'($urandom_range(0, 1)));
    end
    in_tvalid <= 1'b0;

    // Drain and settle
    while (board.expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/suv_pkg.sv
rtl/suv_step.sv
rtl/strict_utf8_validator.sv
rtl/suv_chk.sv
tb/strict_utf8_validator_tb.sv
